/* hdl/rfrf_pkg.sv */
// Shared types, constants and codes for the ring frame receive and forward core.
package rfrf_pkg;

    // Frame layout.
    localparam logic [7:0] FRAME_HEADER = 8'd30;

    // Configuration register file.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NODE_ID      = 2'd0,
        REG_SOURCE_COUNT = 2'd1,
        REG_TYPE_COUNT   = 2'd2,
        REG_DEBUG_TYPE   = 2'd3
    } t_reg_idx;

    localparam logic [7:0] NODE_ID_RESET      = 8'd0;
    localparam logic [7:0] SOURCE_COUNT_RESET = 8'd8;
    localparam logic [7:0] TYPE_COUNT_RESET   = 8'd16;
    localparam logic [7:0] DEBUG_TYPE_RESET   = 8'd0;

    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] source_count;
        logic [7:0] type_count;
        logic [7:0] debug_type;
    } t_cfg;

    // Command queue between the parser and the result sequencer.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,  // forward one payload byte
        CMD_DEBUG = 2'd1,  // forward a debug frame (four bytes)
        CMD_MSG   = 2'd2   // forward a frame and deliver it as a message
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] sender;
        logic [7:0] mtype;
        logic [7:0] data;
    } t_cmd;

    // Result kinds.
    localparam logic KIND_FORWARD = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [7:0] msg_sender;
        logic [7:0] msg_type;
        logic [7:0] msg_data;
        logic       last;
    } t_result;

    // Result sequencer step counter.
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_HEADER  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SENDER  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TYPE    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DATA    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DELIVER = 3'd4;

endpackage

/* hdl/ring_frame_receive_forward_core.sv */
// Top level of the ring frame receive and forward core.
// Received link bytes enter through a queue-style port (push/full) and are taken one per
// cycle while the internal command queue has room. A parser classifies each byte and
// queues at most one command; a sequencer turns each command into one result (payload
// byte), four results (debug frame) or five results (forwarded frame plus delivered
// message), one result per cycle while pop keeps the single output register (empty/pop)
// free; the sequencer sets the sustained rate. The first result of an accepted byte is
// written into the command queue and then into the output register before it reaches
// the result ports.
// Configuration registers are written through i_cfg_we/i_cfg_addr/i_cfg_data while
// the core is idle; the user is bound to this and the block itself does not enforce it.
module ring_frame_receive_forward_core
    import rfrf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_rx_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_kind,
    output logic [7:0]            o_tx_byte,
    output logic [7:0]            o_msg_sender,
    output logic [7:0]            o_msg_type,
    output logic [7:0]            o_msg_data,
    output logic                  o_last
);

    t_cfg    r_cfg;
    logic    accept;
    logic    cmd_push;
    t_cmd    cmd_in;
    t_cmd    cmd_head;
    logic    cmd_pop;
    logic    q_full;
    logic    q_empty;
    t_result result;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id      <= NODE_ID_RESET;
            r_cfg.source_count <= SOURCE_COUNT_RESET;
            r_cfg.type_count   <= TYPE_COUNT_RESET;
            r_cfg.debug_type   <= DEBUG_TYPE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_NODE_ID:      r_cfg.node_id      <= i_cfg_data;
                REG_SOURCE_COUNT: r_cfg.source_count <= i_cfg_data;
                REG_TYPE_COUNT:   r_cfg.type_count   <= i_cfg_data;
                REG_DEBUG_TYPE:   r_cfg.debug_type   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: frame parser.
    rfrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Command queue between the two halves.
    rfrf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: result sequencer.
    rfrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_kind       = result.kind;
    assign o_tx_byte    = result.tx_byte;
    assign o_msg_sender = result.msg_sender;
    assign o_msg_type   = result.msg_type;
    assign o_msg_data   = result.msg_data;
    assign o_last       = result.last;

endmodule

/* hdl/rfrf_front.sv */
// Frame parser: hunts for the header, collects frames and classifies them into commands.
module rfrf_front
    import rfrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_byte_index, n_byte_index;
    logic [7:0] r_frame_sender, n_frame_sender;
    logic [7:0] r_frame_type, n_frame_type;
    logic [7:0] r_payload_left, n_payload_left;
    logic       r_payload_forward, n_payload_forward;

    logic [7:0] left_dec;
    logic       sender_bad;
    logic       type_bad;

    assign left_dec   = (r_payload_left != 8'd0) ? (r_payload_left - 8'd1) : 8'd0;
    assign sender_bad = (r_frame_sender >= i_cfg.source_count);
    assign type_bad   = (r_frame_type >= i_cfg.type_count);

    // Next-state and command decode for one accepted byte.
    always_comb begin
        n_phase           = r_phase;
        n_byte_index      = r_byte_index;
        n_frame_sender    = r_frame_sender;
        n_frame_type      = r_frame_type;
        n_payload_left    = r_payload_left;
        n_payload_forward = r_payload_forward;
        o_cmd_push        = 1'b0;
        o_cmd.kind        = CMD_BYTE;
        o_cmd.sender      = r_frame_sender;
        o_cmd.mtype       = r_frame_type;
        o_cmd.data        = i_rx_byte;

        if (i_accept) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_cmd_push     = r_payload_forward;
                    n_payload_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase           = PH_HUNT;
                        n_payload_forward = 1'b0;
                    end
                end
                PH_COLLECT: begin
                    if (r_byte_index == 2'd1) begin
                        n_frame_sender = i_rx_byte;
                        n_byte_index   = 2'd2;
                    end else if (r_byte_index == 2'd2) begin
                        n_frame_type = i_rx_byte;
                        n_byte_index = 2'd3;
                    end else begin
                        // Fourth byte completes the frame.
                        n_byte_index = 2'd0;
                        n_phase      = PH_HUNT;
                        if (r_frame_type == i_cfg.debug_type) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_DEBUG;
                            if (i_rx_byte != 8'd0) begin
                                n_phase           = PH_PAYLOAD;
                                n_payload_left    = i_rx_byte;
                                n_payload_forward = (r_frame_sender != i_cfg.node_id);
                            end
                        end else if (r_frame_sender != i_cfg.node_id &&
                                     !sender_bad && !type_bad) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = CMD_MSG;
                        end
                    end
                end
                PH_HUNT: begin
                    if (i_rx_byte == FRAME_HEADER) begin
                        n_phase      = PH_COLLECT;
                        n_byte_index = 2'd1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_HUNT;
            r_byte_index      <= 2'd0;
            r_frame_sender    <= 8'd0;
            r_frame_type      <= 8'd0;
            r_payload_left    <= 8'd0;
            r_payload_forward <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_byte_index      <= n_byte_index;
            r_frame_sender    <= n_frame_sender;
            r_frame_type      <= n_frame_type;
            r_payload_left    <= n_payload_left;
            r_payload_forward <= n_payload_forward;
        end
    end

endmodule

/* hdl/rfrf_cmd_queue.sv */
// Short command queue that decouples the parser from the result sequencer.
module rfrf_cmd_queue
    import rfrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/rfrf_back.sv */
// Result sequencer: turns each command into results, one per cycle unless stalled.
module rfrf_back
    import rfrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_result           r_out;

    t_result           n_result;
    logic              final_step;
    logic              advance;
    logic              produce;

    // Output slot frees when empty or when its transaction is taken.
    assign advance   = !r_out_valid || i_pop;
    assign produce   = advance && !i_cmd_empty;
    assign o_cmd_pop = produce && final_step;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // Result for the current step of the head command.
    always_comb begin
        n_result            = '0;
        n_result.kind       = KIND_FORWARD;
        final_step          = 1'b0;
        if (i_cmd.kind == CMD_BYTE) begin
            n_result.tx_byte = i_cmd.data;
            n_result.last    = 1'b1;
            final_step       = 1'b1;
        end else begin
            case (r_step)
                STEP_HEADER: n_result.tx_byte = FRAME_HEADER;
                STEP_SENDER: n_result.tx_byte = i_cmd.sender;
                STEP_TYPE:   n_result.tx_byte = i_cmd.mtype;
                STEP_DATA: begin
                    n_result.tx_byte = i_cmd.data;
                    n_result.last    = (i_cmd.kind == CMD_DEBUG);
                    final_step       = (i_cmd.kind == CMD_DEBUG);
                end
                default: begin
                    n_result.kind       = KIND_DELIVER;
                    n_result.msg_sender = i_cmd.sender;
                    n_result.msg_type   = i_cmd.mtype;
                    n_result.msg_data   = i_cmd.data;
                    n_result.last       = 1'b1;
                    final_step          = 1'b1;
                end
            endcase
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= n_result;
        end
    end

    // Step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_HEADER;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= produce;
            end
            if (produce) begin
                r_step <= final_step ? STEP_HEADER : (r_step + STEP_W'(1));
            end
        end
    end

endmodule

/* dv/ring_frame_receive_forward_core_tb.sv */
// Self-checking testbench for the ring frame receive and forward core.
`timescale 1ns / 100ps

module ring_frame_receive_forward_core_tb;
    import rfrf_pkg::*;

    localparam int IDLE_LIMIT    = 2000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 8;     // settle time after the last expected result
    localparam int PHASE_BYTES   = 16;    // minimum frame bytes per random setting phase
    localparam int N_PHASES      = 5;

    // Parser state of the link predictor.
    typedef enum logic [1:0] {
        LNK_HUNT    = 2'd0,
        LNK_COLLECT = 2'd1,
        LNK_PAYLOAD = 2'd2
    } t_lnk_phase;

    // One row of the directed stimulus: a link byte and, where typed in,
    // the number of results and the final result it must cause.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [2:0] n_res;
        t_result    tail;
    } t_dir_row;

    localparam t_result NO_RES = '0;
    localparam int N_DIR = 27;
    localparam t_dir_row DIRECTED [N_DIR] = '{
        // A non-header byte while hunting is ignored.
        '{8'h00, 1'b1, 3'd0, NO_RES},
        // Debug frame from another node; its one payload byte is forwarded.
        '{FRAME_HEADER, 1'b0, 3'd0, NO_RES},
        '{8'd1, 1'b0, 3'd0, NO_RES},
        '{DEBUG_TYPE_RESET, 1'b0, 3'd0, NO_RES},
        '{8'd1, 1'b1, 3'd4, '{KIND_FORWARD, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1}},
        '{8'hFF, 1'b1, 3'd1, '{KIND_FORWARD, 8'hFF, 8'd0, 8'd0, 8'd0, 1'b1}},
        // Message frame with the largest valid sender and type.
        '{FRAME_HEADER, 1'b0, 3'd0, NO_RES},
        '{SOURCE_COUNT_RESET - 8'd1, 1'b0, 3'd0, NO_RES},
        '{TYPE_COUNT_RESET - 8'd1, 1'b0, 3'd0, NO_RES},
        '{8'hFF, 1'b1, 3'd5, '{KIND_DELIVER, 8'd0, 8'd7, 8'd15, 8'hFF, 1'b1}},
        // Sender and type just out of range: the frame is dropped.
        '{FRAME_HEADER, 1'b0, 3'd0, NO_RES},
        '{SOURCE_COUNT_RESET, 1'b0, 3'd0, NO_RES},
        '{TYPE_COUNT_RESET, 1'b0, 3'd0, NO_RES},
        '{8'd5, 1'b1, 3'd0, NO_RES},
        // Ordinary frame sent by this node: dropped.
        '{FRAME_HEADER, 1'b0, 3'd0, NO_RES},
        '{NODE_ID_RESET, 1'b0, 3'd0, NO_RES},
        '{8'd4, 1'b0, 3'd0, NO_RES},
        '{8'd9, 1'b1, 3'd0, NO_RES},
        // Debug frame from this node: forwarded, its payload consumed silently.
        '{FRAME_HEADER, 1'b0, 3'd0, NO_RES},
        '{NODE_ID_RESET, 1'b0, 3'd0, NO_RES},
        '{DEBUG_TYPE_RESET, 1'b0, 3'd0, NO_RES},
        '{8'd1, 1'b1, 3'd4, '{KIND_FORWARD, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1}},
        '{8'h00, 1'b1, 3'd0, NO_RES},
        // Debug frame from an out-of-range sender with no payload.
        '{FRAME_HEADER, 1'b0, 3'd0, NO_RES},
        '{8'd200, 1'b0, 3'd0, NO_RES},
        '{DEBUG_TYPE_RESET, 1'b0, 3'd0, NO_RES},
        '{8'h00, 1'b1, 3'd4, '{KIND_FORWARD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1}}
    };

    // Block ports.
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  push         = 1'b0;
    logic                  full;
    logic [7:0]            i_rx_byte    = '0;
    logic                  empty;
    logic                  pop          = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_tx_byte;
    logic [7:0]            o_msg_sender;
    logic [7:0]            o_msg_type;
    logic [7:0]            o_msg_data;
    logic                  o_last;

    // Predictor copy of the configuration and parser state.
    t_cfg       cfg_model;
    t_lnk_phase lnk_phase;
    logic [1:0] lnk_index;
    logic [7:0] lnk_sender;
    logic [7:0] lnk_type;
    logic [7:0] lnk_left;
    logic       lnk_fwd;

    t_result    link_res [5];
    t_result    pending_results [$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int msgs_seen      = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    ring_frame_receive_forward_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_msg_sender (o_msg_sender),
        .o_msg_type   (o_msg_type),
        .o_msg_data   (o_msg_data),
        .o_last       (o_last)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic t_result make_res(input logic kind, input logic [7:0] tx,
                                         input logic [7:0] snd, input logic [7:0] typ,
                                         input logic [7:0] dat, input logic last);
        t_result r;
        r = '{kind, tx, snd, typ, dat, last};
        return r;
    endfunction

    function automatic t_dir_row plain_row(input logic [7:0] b);
        t_dir_row r;
        r = '{b, 1'b0, 3'd0, NO_RES};
        return r;
    endfunction

    // Link byte predictor: advances the parser state and fills link_res.
    task automatic parse_link_byte(input logic [7:0] b, output int n);
        n = 0;
        case (lnk_phase)
            LNK_PAYLOAD: begin
                if (lnk_fwd) begin
                    link_res[0] = make_res(KIND_FORWARD, b, 8'd0, 8'd0, 8'd0, 1'b1);
                    n = 1;
                end
                if (lnk_left != 8'd0) lnk_left = lnk_left - 8'd1;
                if (lnk_left == 8'd0) begin
                    lnk_phase = LNK_HUNT;
                    lnk_fwd   = 1'b0;
                end
            end
            LNK_COLLECT: begin
                if (lnk_index == 2'd1) begin
                    lnk_sender = b;
                    lnk_index  = 2'd2;
                end else if (lnk_index == 2'd2) begin
                    lnk_type  = b;
                    lnk_index = 2'd3;
                end else begin
                    // Frame complete: the debug check comes before all others.
                    lnk_index = 2'd0;
                    lnk_phase = LNK_HUNT;
                    link_res[0] = make_res(KIND_FORWARD, FRAME_HEADER, 8'd0, 8'd0, 8'd0, 1'b0);
                    link_res[1] = make_res(KIND_FORWARD, lnk_sender, 8'd0, 8'd0, 8'd0, 1'b0);
                    link_res[2] = make_res(KIND_FORWARD, lnk_type, 8'd0, 8'd0, 8'd0, 1'b0);
                    link_res[3] = make_res(KIND_FORWARD, b, 8'd0, 8'd0, 8'd0, 1'b0);
                    if (lnk_type == cfg_model.debug_type) begin
                        link_res[3].last = 1'b1;
                        n = 4;
                        if (b != 8'd0) begin
                            lnk_phase = LNK_PAYLOAD;
                            lnk_left  = b;
                            lnk_fwd   = (lnk_sender != cfg_model.node_id);
                        end
                    end else if (lnk_sender != cfg_model.node_id &&
                                 lnk_sender < cfg_model.source_count &&
                                 lnk_type < cfg_model.type_count) begin
                        link_res[4] = make_res(KIND_DELIVER, 8'd0, lnk_sender, lnk_type, b, 1'b1);
                        n = 5;
                    end
                end
            end
            default: begin
                if (b == FRAME_HEADER) begin
                    lnk_phase = LNK_COLLECT;
                    lnk_index = 2'd1;
                end
            end
        endcase
    endtask

    // Send one link byte; on acceptance predict its results.
    task automatic send_rx(input t_dir_row row);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= row.rx;
        do @(posedge i_clk); while (full);
        bytes_sent++;
        parse_link_byte(row.rx, n);
        if (row.typed && n != int'(row.n_res))
            report_error($sformatf("byte %0d: table gives %0d results, predictor %0d",
                                   row.rx, row.n_res, n));
        for (int k = 0; k < n; k++)
            pending_results.push_back((row.typed && k == n - 1) ? row.tail : link_res[k]);
    endtask

    // Stop sending and let every expected result drain, then settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_NODE_ID:      cfg_model.node_id      = val;
            REG_SOURCE_COUNT: cfg_model.source_count = val;
            REG_TYPE_COUNT:   cfg_model.type_count   = val;
            default:          cfg_model.debug_type   = val;
        endcase
    endtask

    task automatic program_cfg(input t_cfg c);
        write_reg(REG_NODE_ID, c.node_id);
        write_reg(REG_SOURCE_COUNT, c.source_count);
        write_reg(REG_TYPE_COUNT, c.type_count);
        write_reg(REG_DEBUG_TYPE, c.debug_type);
        i_cfg_we <= 1'b0;
    endtask

    // One frame with random content biased toward the interesting cases;
    // now and then it is cut short.
    task automatic send_random_frame(output int n_sent);
        logic [7:0] frame [4];
        logic [7:0] dat;
        int         cut;
        bit         dbg;
        frame[0] = FRAME_HEADER;
        case ($urandom_range(0, 3))
            0: frame[1] = cfg_model.node_id;
            1: frame[1] = (cfg_model.source_count != 8'd0) ?
                   8'($urandom_range(0, cfg_model.source_count - 1)) : 8'($urandom);
            default: frame[1] = 8'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: frame[2] = cfg_model.debug_type;
            1: frame[2] = (cfg_model.type_count != 8'd0) ?
                   8'($urandom_range(0, cfg_model.type_count - 1)) : 8'($urandom);
            default: frame[2] = 8'($urandom);
        endcase
        dbg = (frame[2] == cfg_model.debug_type);
        if (dbg)
            dat = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 40))
                                               : 8'($urandom_range(0, 5));
        else
            dat = 8'($urandom);
        frame[3] = dat;
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4;
        n_sent = 0;
        for (int k = 0; k < cut; k++) begin
            send_rx(plain_row(frame[k]));
            n_sent++;
        end
        if (cut == 4 && dbg) begin
            for (int k = 0; k < int'(dat); k++) begin
                send_rx(plain_row(8'($urandom)));
                n_sent++;
            end
        end
    endtask

    // Result side: pop with a random stall rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is 0x%02h, expected 0x%02h",
                                   results_seen, name, got, want));
    endtask

    // Compare each popped transaction with the oldest expectation; watchdog.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got = '{o_kind, o_tx_byte, o_msg_sender, o_msg_type, o_msg_data, o_last};
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected",
                                           results_seen));
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 8'(got.kind), 8'(want.kind));
                    check_field("tx_byte", got.tx_byte, want.tx_byte);
                    check_field("msg_sender", got.msg_sender, want.msg_sender);
                    check_field("msg_type", got.msg_type, want.msg_type);
                    check_field("msg_data", got.msg_data, want.msg_data);
                    check_field("last", 8'(got.last), 8'(want.last));
                end
                if (got.kind == KIND_DELIVER) msgs_seen++;
                results_seen++;
            end
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random phases over several settings.
    initial begin
        t_cfg c;
        int   sent;
        int   phase_bytes;
        bit   paused;
        cfg_model  = '{NODE_ID_RESET, SOURCE_COUNT_RESET, TYPE_COUNT_RESET, DEBUG_TYPE_RESET};
        lnk_phase  = LNK_HUNT;
        lnk_index  = 2'd0;
        lnk_sender = 8'd0;
        lnk_type   = 8'd0;
        lnk_left   = 8'd0;
        lnk_fwd    = 1'b0;
        paused     = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset settings, no idling.
        for (int r = 0; r < N_DIR; r++)
            send_rx(DIRECTED[r]);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p)
                0: c = '{8'd0, 8'd255, 8'd255, 8'd255};
                1: c = '{8'd255, 8'd1, 8'd1, 8'd0};
                2: c = '{8'($urandom), 8'd0, 8'($urandom_range(1, 16)), 8'($urandom)};
                3: c = '{8'($urandom), 8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
                         8'($urandom_range(0, 15))};
                default: c = '{8'($urandom), 8'($urandom_range(1, 255)), 8'd0, 8'($urandom)};
            endcase
            program_cfg(c);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                // Occasional noise bytes between frames.
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 3)) send_rx(plain_row(8'($urandom)));
                end
                send_random_frame(sent);
                phase_bytes += sent;
                // Once, hold the sender until every expected result has come.
                if (p == 1 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
                    push <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        $display("Sent %0d link bytes over the reset setting and %0d programmed settings,",
                 bytes_sent, N_PHASES);
        $display("checked %0d results including %0d delivered messages.",
                 results_seen, msgs_seen);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
